FILE: rtl/ofrt_pkg.sv
// Shared codes for the open-file reference-count table.
// Request and status codes and the field widths of the stream payloads.
// No dependencies.
`default_nettype none

package ofrt_pkg;

  localparam int unsigned InodeW  = 32;
  localparam int unsigned FuncW   = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned FieldW  = 16;

  localparam logic [FuncW-1:0] FUNC_OPEN   = 2'd0;
  localparam logic [FuncW-1:0] FUNC_CLOSE  = 2'd1;
  localparam logic [FuncW-1:0] FUNC_LOOKUP = 2'd2;

  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [StatusW-1:0] ST_INVALID   = 2'd2;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd3;

  localparam logic [InodeW-1:0] ROOT_INODE  = 32'd0;
  localparam logic [InodeW-1:0] LIMIT_RESET = 32'd4096;

endpackage

`default_nettype wire

FILE: rtl/ofrt_entry_ram.sv
// Entry store of the open-file table: one write port, one read port.
// Read data registered. No dependencies.
`default_nettype none

module ofrt_entry_ram #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned DATA_W = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/open_file_refcount_table_core.sv
// Open-file reference-count table, top level.
// Uses ofrt_pkg and the entry store ofrt_entry_ram.
//
// Usage
//   Requests arrive on the slave stream: s_tdata_i carries the inode number,
//   s_tuser_i the request code and the write flag. One result per request
//   leaves on the master stream with status, root flag, slot and counts.
//   inode_limit is written through cfg_we_i / cfg_wdata_i while idle.
// Timing
//   One request at a time. A table request reads every slot from the entry
//   store in turn (one read a cycle), then decides and writes one entry
//   back when an open finds or takes a slot or a close finds its slot;
//   the result is registered after that. Root and out-of-range requests
//   skip the scan and go straight to the emit state.
// Reset
//   Clears all valid bits at once (no clearing pass) and sets inode_limit
//   to 4096. Entry contents are left as they are.
// Back-pressure
//   The result waits in the output register while m_tready_i is low; the
//   next request is still taken and scanned, and only its result waits.
`default_nettype none

module open_file_refcount_table_core #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: inode_limit
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  // request stream
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [31:0] s_tdata_i,  // [31:0] inode_number
  input  wire logic [2:0]  s_tuser_i,  // [1:0] func, [2] write_flag
  // result stream
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic      [39:0] m_tdata_o,  // [3:0] slot_index, [19:4] open_count,
                                       // [35:20] writer_count, [39:36] zero
  output logic      [2:0]  m_tuser_o   // [1:0] status, [2] is_root
);

  import ofrt_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam logic [COUNT_BITS-1:0] CountOne = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] CountZero = '0;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  typedef struct packed {
    logic [InodeW-1:0]     inode;
    logic [COUNT_BITS-1:0] opens;
    logic [COUNT_BITS-1:0] writers;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_EMIT
  } state_e;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == CountMax) ? v : v + CountOne;
  endfunction

  state_e state_q;

  logic [InodeW-1:0]        limit_q;
  logic [TABLE_ENTRIES-1:0] valid_q;

  // latched request
  logic [FuncW-1:0]  func_q;
  logic [InodeW-1:0] ino_q;
  logic              wr_q;

  // scan pipeline
  logic [CntW-1:0] rd_cnt_q;
  logic            cmp_vld_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic            hit_q;
  logic [IdxW-1:0] hit_idx_q;
  entry_t          hit_ent_q;
  logic            free_q;
  logic [IdxW-1:0] free_idx_q;

  // pending result
  logic [StatusW-1:0]    res_status_q;
  logic                  res_root_q;
  logic [IdxW-1:0]       res_slot_q;
  logic [COUNT_BITS-1:0] res_open_q;
  logic [COUNT_BITS-1:0] res_wr_q;

  logic        m_tvalid_q;
  logic [39:0] m_tdata_q;
  logic [2:0]  m_tuser_q;

  logic s_fire;
  logic rd_issue;
  logic emit_go;

  entry_t ram_rdata;
  entry_t ram_wdata;
  logic   ram_we;
  logic [IdxW-1:0] ram_waddr;

  logic cmp_hit;
  logic cmp_free;

  // decision on the last scan results
  logic [StatusW-1:0]    fin_status;
  logic [IdxW-1:0]       fin_slot;
  logic [COUNT_BITS-1:0] fin_open;
  logic [COUNT_BITS-1:0] fin_wr;
  logic                  fin_set;
  logic                  fin_clr;

  assign s_tready_o = (state_q == S_IDLE);
  assign s_fire     = s_tvalid_i && s_tready_o;
  assign rd_issue   = (state_q == S_SCAN) && (rd_cnt_q < CntW'(TABLE_ENTRIES));
  assign emit_go    = (state_q == S_EMIT) && (!m_tvalid_q || m_tready_i);

  assign cmp_hit  = cmp_vld_q && valid_q[cmp_idx_q] && !hit_q && (ram_rdata.inode == ino_q);
  assign cmp_free = cmp_vld_q && !valid_q[cmp_idx_q] && !free_q;

  ofrt_entry_ram #(
    .DEPTH  (TABLE_ENTRIES),
    .DATA_W ($bits(entry_t))
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_cnt_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    fin_status = ST_OK;
    fin_slot   = hit_idx_q;
    fin_open   = hit_ent_q.opens;
    fin_wr     = hit_ent_q.writers;
    fin_set    = 1'b0;
    fin_clr    = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = hit_idx_q;
    ram_wdata  = hit_ent_q;
    case (func_q)
      FUNC_OPEN: begin
        if (hit_q) begin
          fin_open = sat_inc(hit_ent_q.opens);
          fin_wr   = wr_q ? sat_inc(hit_ent_q.writers) : hit_ent_q.writers;
          ram_we   = 1'b1;
        end else if (free_q) begin
          fin_slot  = free_idx_q;
          fin_open  = CountOne;
          fin_wr    = wr_q ? CountOne : CountZero;
          fin_set   = 1'b1;
          ram_we    = 1'b1;
          ram_waddr = free_idx_q;
        end else begin
          fin_status = ST_FULL;
        end
      end
      FUNC_CLOSE: begin
        if (hit_q) begin
          if (wr_q && (hit_ent_q.writers != CountZero)) begin
            fin_wr = hit_ent_q.writers - CountOne;
          end
          if (hit_ent_q.opens != CountZero) begin
            fin_open = hit_ent_q.opens - CountOne;
          end
          fin_clr = (fin_open == CountZero);
          ram_we  = 1'b1;
        end else begin
          fin_status = ST_NOT_FOUND;
        end
      end
      default: begin
        // lookup, and the unused code treated alike
        if (!hit_q) begin
          fin_status = ST_NOT_FOUND;
        end
      end
    endcase
    ram_we            = ram_we && (state_q == S_FINISH);
    ram_wdata.inode   = ino_q;
    ram_wdata.opens   = fin_open;
    ram_wdata.writers = fin_wr;
    if (fin_status != ST_OK) begin
      fin_slot = '0;
      fin_open = '0;
      fin_wr   = '0;
    end
  end

  // control state, valid bits, config and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      limit_q    <= LIMIT_RESET;
      valid_q    <= '0;
      rd_cnt_q   <= '0;
      cmp_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      // a new result replaces the one leaving in the same cycle
      if (emit_go) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
      cmp_vld_q <= rd_issue;
      if (rd_issue) begin
        rd_cnt_q <= rd_cnt_q + CntW'(1);
      end
      if (cmp_hit) begin
        hit_q <= 1'b1;
      end
      if (cmp_free) begin
        free_q <= 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (s_fire) begin
            rd_cnt_q <= '0;
            hit_q    <= 1'b0;
            free_q   <= 1'b0;
            if ((s_tdata_i == ROOT_INODE) || (s_tdata_i >= limit_q)) begin
              state_q <= S_EMIT;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cmp_vld_q && (cmp_idx_q == LastIdx)) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (fin_set) begin
            valid_q[free_idx_q] <= 1'b1;
          end
          if (fin_clr) begin
            valid_q[hit_idx_q] <= 1'b0;
          end
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      func_q       <= s_tuser_i[1:0];
      ino_q        <= s_tdata_i;
      wr_q         <= s_tuser_i[2];
      res_root_q   <= (s_tdata_i == ROOT_INODE);
      res_status_q <= (s_tdata_i == ROOT_INODE) ? ST_OK : ST_INVALID;
      res_slot_q   <= '0;
      res_open_q   <= '0;
      res_wr_q     <= '0;
    end
    if (rd_issue) begin
      cmp_idx_q <= rd_cnt_q[IdxW-1:0];
    end
    if (cmp_hit) begin
      hit_idx_q <= cmp_idx_q;
      hit_ent_q <= ram_rdata;
    end
    if (cmp_free) begin
      free_idx_q <= cmp_idx_q;
    end
    if (state_q == S_FINISH) begin
      res_status_q <= fin_status;
      res_root_q   <= 1'b0;
      res_slot_q   <= fin_slot;
      res_open_q   <= fin_open;
      res_wr_q     <= fin_wr;
    end
    if (emit_go) begin
      m_tdata_q <= {4'b0000, FieldW'(res_wr_q), FieldW'(res_open_q), SlotW'(res_slot_q)};
      m_tuser_q <= {res_root_q, res_status_q};
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;
  assign m_tuser_o  = m_tuser_q;

endmodule

`default_nettype wire

FILE: bench/ofrt_refcount_monitor.sv
// Checker for the open-file reference-count table: watches the config,
// request and result channels, predicts each result and compares it.
// Depends on ofrt_pkg.
`timescale 1ns / 100ps

module ofrt_refcount_monitor #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  input  wire logic [31:0] s_tdata_i,
  input  wire logic [2:0]  s_tuser_i,
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic [39:0] m_tdata_i,
  input  wire logic [2:0]  m_tuser_i,
  output int unsigned      pending_o,
  output int unsigned      mismatches_o
);

  import ofrt_pkg::*;

  localparam logic [FieldW-1:0] COUNT_TOP = '1;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               is_root;
    logic [SlotW-1:0]   slot;
    logic [FieldW-1:0]  opens;
    logic [FieldW-1:0]  writers;
  } table_result_t;

  // shadow copy of the entry store and the limit register
  logic              slot_used    [SLOTS];
  logic [InodeW-1:0] slot_inode   [SLOTS];
  logic [FieldW-1:0] slot_opens   [SLOTS];
  logic [FieldW-1:0] slot_writers [SLOTS];
  logic [InodeW-1:0] inode_limit;

  table_result_t expected_results[$];

  function automatic logic [FieldW-1:0] bump(input logic [FieldW-1:0] v);
    return (v == COUNT_TOP) ? v : v + 1'b1;
  endfunction

  function automatic table_result_t predict_request(input logic [FuncW-1:0] func,
                                                    input logic [InodeW-1:0] ino,
                                                    input logic wr);
    table_result_t res;
    int hit;
    int spare;
    res   = '0;
    hit   = -1;
    spare = -1;
    if (ino == ROOT_INODE) begin
      res.is_root = 1'b1;
      return res;
    end
    if (ino >= inode_limit) begin
      res.status = ST_INVALID;
      return res;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i]) begin
        if (hit < 0 && slot_inode[i] == ino) hit = i;
      end else if (spare < 0) begin
        spare = i;
      end
    end
    if (func == FUNC_OPEN) begin
      if (hit >= 0) begin
        slot_opens[hit] = bump(slot_opens[hit]);
        if (wr) slot_writers[hit] = bump(slot_writers[hit]);
      end else if (spare >= 0) begin
        hit               = spare;
        slot_used[hit]    = 1'b1;
        slot_inode[hit]   = ino;
        slot_opens[hit]   = FieldW'(1);
        slot_writers[hit] = FieldW'(wr);
      end else begin
        res.status = ST_FULL;
        return res;
      end
    end else begin
      // close, lookup and the spare code (treated as lookup)
      if (hit < 0) begin
        res.status = ST_NOT_FOUND;
        return res;
      end
      if (func == FUNC_CLOSE) begin
        if (wr && slot_writers[hit] != 0) slot_writers[hit] = slot_writers[hit] - 1'b1;
        if (slot_opens[hit] != 0) slot_opens[hit] = slot_opens[hit] - 1'b1;
        if (slot_opens[hit] == 0) slot_used[hit] = 1'b0;
      end
    end
    res.slot    = hit[SlotW-1:0];
    res.opens   = slot_opens[hit];
    res.writers = slot_writers[hit];
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    table_result_t want;
    table_result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
      inode_limit = LIMIT_RESET;
      expected_results.delete();
      mismatches_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.status  = m_tuser_i[1:0];
        got.is_root = m_tuser_i[2];
        got.slot    = m_tdata_i[3:0];
        got.opens   = m_tdata_i[19:4];
        got.writers = m_tdata_i[35:20];
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatches_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("is_root", 32'(want.is_root), 32'(got.is_root));
          check_field("slot_index", 32'(want.slot), 32'(got.slot));
          check_field("open_count", 32'(want.opens), 32'(got.opens));
          check_field("writer_count", 32'(want.writers), 32'(got.writers));
        end
      end
      if (cfg_we_i) inode_limit = cfg_wdata_i;
      if (s_tvalid_i && s_tready_i)
        expected_results.push_back(predict_request(s_tuser_i[1:0], s_tdata_i, s_tuser_i[2]));
    end
    pending_o = expected_results.size();
  end

endmodule

FILE: bench/tb_open_file_refcount_table_core.sv
// Top of the open-file reference-count table bench: clock, reset, stimulus
// and verdict. Uses ofrt_pkg, the core and ofrt_refcount_monitor.
`timescale 1ns / 100ps

module tb_open_file_refcount_table_core;
  import ofrt_pkg::*;

  // func code 3 is unused by the block; it must behave as a lookup
  localparam logic [FuncW-1:0] FUNC_SPARE = 2'd3;
  localparam int unsigned POOL_SIZE = 20;   // more inodes than slots: table fills
  localparam longint CYCLE_LIMIT = 10_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] inode_number
  logic [2:0]  s_tuser = '0;   // [1:0] func, [2] write_flag
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [3:0] slot, [19:4] opens, [35:20] writers
  logic [2:0]  m_tuser;        // [1:0] status, [2] is_root

  int unsigned pending;
  int unsigned mismatches;

  // request transfer seen at the last rising edge, read at the falling edge
  bit          req_taken;
  int unsigned burst_left;
  logic [InodeW-1:0] cur_limit;
  logic [InodeW-1:0] inode_pool [POOL_SIZE];
  longint      cycle_count;

  always #10 clk = ~clk;

  open_file_refcount_table_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_o  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_o   (m_tdata),
    .m_tuser_o   (m_tuser)
  );

  ofrt_refcount_monitor monitor (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  always @(posedge clk) req_taken <= s_tvalid && s_tready;

  // Result side: the stall pattern is picked at random among always
  // ready, one stall in four, coin toss and long stalls (ready 1 in 9).
  always @(negedge clk) begin : result_stalls
    static int unsigned tick = 0;
    static int unsigned mode = 0;
    tick++;
    if (tick % 50 == 0) mode = $urandom_range(0, 3);
    case (mode)
      0: m_tready = 1'b1;
      1: m_tready = (tick % 4 != 3);
      2: m_tready = 1'($urandom_range(0, 1));
      default: m_tready = (tick % 9 == 0);
    endcase
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // One request transfer. Called and returns at a falling edge. The sender
  // works in bursts; between bursts tvalid drops for a random gap.
  task automatic send_request(input logic [FuncW-1:0] func,
                              input logic [InodeW-1:0] ino, input logic wr);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    s_tdata  = ino;
    s_tuser  = {wr, func};
    s_tvalid = 1'b1;
    do @(negedge clk); while (!req_taken);
  endtask

  // Hold off until every expected result is back, then let the block settle.
  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  // Only while idle: after reset or after wait_drained.
  task automatic write_limit(input logic [31:0] value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    cur_limit = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Inode pool for a phase: a cluster of valid numbers so that opens, closes
  // and lookups meet each other; small limits get 1..POOL_SIZE, some invalid.
  task automatic fill_pool();
    logic [InodeW-1:0] base;
    int unsigned stride;
    if (cur_limit > 200) begin
      stride = $urandom_range(1, 7);
      base   = $urandom_range(1, cur_limit - 200);
    end else begin
      stride = 1;
      base   = 1;
    end
    for (int k = 0; k < POOL_SIZE; k++) inode_pool[k] = base + k * stride;
  endtask

  function automatic logic [InodeW-1:0] pick_inode();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return ROOT_INODE;
    if (r < 8) return cur_limit + $urandom_range(0, 3);   // at or just past the limit
    if (r < 12) return $urandom();
    return inode_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic [FuncW-1:0] pick_func();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 44) return FUNC_OPEN;
    if (r < 80) return FUNC_CLOSE;
    if (r < 95) return FUNC_LOOKUP;
    return FUNC_SPARE;
  endfunction

  task automatic random_phase(input logic [31:0] limit, input int unsigned count);
    wait_drained();
    write_limit(limit);
    fill_pool();
    for (int n = 0; n < count; n++)
      send_request(pick_func(), pick_inode(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    burst_left = 0;
    cur_limit  = LIMIT_RESET;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: root for every func, limit edges, not found, spare code,
    // writer count held at zero, a freed slot reporting its writers, reuse.
    send_request(FUNC_LOOKUP, ROOT_INODE, 1'b0);
    send_request(FUNC_CLOSE, ROOT_INODE, 1'b1);
    send_request(FUNC_OPEN, ROOT_INODE, 1'b1);
    send_request(FUNC_SPARE, ROOT_INODE, 1'b0);
    send_request(FUNC_OPEN, LIMIT_RESET - 1, 1'b1);
    send_request(FUNC_OPEN, LIMIT_RESET, 1'b1);
    send_request(FUNC_LOOKUP, LIMIT_RESET, 1'b0);
    send_request(FUNC_CLOSE, 32'hFFFF_FFFF, 1'b1);
    send_request(FUNC_LOOKUP, 32'd7, 1'b0);
    send_request(FUNC_CLOSE, 32'd7, 1'b1);
    send_request(FUNC_OPEN, LIMIT_RESET - 1, 1'b0);
    send_request(FUNC_SPARE, LIMIT_RESET - 1, 1'b1);
    send_request(FUNC_CLOSE, LIMIT_RESET - 1, 1'b1);
    send_request(FUNC_CLOSE, LIMIT_RESET - 1, 1'b1);
    send_request(FUNC_LOOKUP, LIMIT_RESET - 1, 1'b0);
    send_request(FUNC_OPEN, 32'd9, 1'b1);
    send_request(FUNC_OPEN, 32'd1, 1'b0);
    send_request(FUNC_CLOSE, 32'd9, 1'b0);
    send_request(FUNC_OPEN, 32'd9, 1'b0);
    send_request(FUNC_CLOSE, 32'd1, 1'b1);

    // Random part across limit settings, extremes included. Each phase
    // first pauses until every expected result is back.
    random_phase(32'd20, 300);
    random_phase(32'hFFFF_FFFF, 300);
    random_phase(32'd1, 60);
    random_phase(32'd300, 350);
    random_phase(32'h8000_0001, 250);
    random_phase(LIMIT_RESET, 450);

    wait_drained();
    if (mismatches == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
